// ===== hw/rtl/deflate_fixed_huffman_symbol_encoder_macros.svh =====
// Assertion helpers for the fixed Huffman symbol encoder.
// Each macro expects clk and rst_n in scope.
`ifndef DEFLATE_FIXED_HUFFMAN_SYMBOL_ENCODER_MACROS_SVH
`define DEFLATE_FIXED_HUFFMAN_SYMBOL_ENCODER_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define DFHE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define DFHE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define DFHE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dfhe_pkg.sv =====
`default_nettype none

package dfhe_pkg;

  // Request codes
  localparam logic [2:0] REQ_HEADER  = 3'd0;
  localparam logic [2:0] REQ_LITERAL = 3'd1;
  localparam logic [2:0] REQ_MATCH   = 3'd2;
  localparam logic [2:0] REQ_EOB     = 3'd3;
  localparam logic [2:0] REQ_FLUSH   = 3'd4;

  // Accumulator geometry: up to 7 pending bits plus up to 31 new bits
  localparam int ACC_W    = 38;
  localparam int CNT_W    = 6;
  localparam int WORD_W   = 31;
  localparam int NBITS_W  = 5;

  // Symbol constants of the literal/length alphabet
  localparam logic [8:0] SYM_EOB       = 9'h100;
  localparam logic [8:0] SYM_LEN_FIRST = 9'h101;
  localparam logic [8:0] SYM_LEN_EXTRA = 9'h109;
  localparam logic [8:0] SYM_LEN_LAST  = 9'h11d;
  localparam logic [7:0] LIT_SPLIT     = 8'd144;

  // Length codes below this index use 7-bit Huffman codes
  localparam logic [4:0] LEN_IDX_SPLIT = 5'd23;
  localparam logic [4:0] LEN_IDX_EXTRA = 5'(SYM_LEN_EXTRA - SYM_LEN_FIRST);
  localparam logic [4:0] LEN_IDX_LAST  = 5'(SYM_LEN_LAST - SYM_LEN_FIRST);
  localparam logic [4:0] DIST_IDX_EXTRA = 5'd4;

  localparam int LEN_CODES  = 29;
  localparam int DIST_CODES = 30;

  localparam logic [8:0] LEN_MIN  = 9'd3;
  localparam logic [8:0] LEN_MAX  = 9'd258;
  localparam logic [15:0] DIST_MIN = 16'd1;
  localparam logic [15:0] DIST_MAX = 16'h8000;

  localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13,
    9'd15, 9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59,
    9'd67, 9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };

  localparam logic [15:0] DIST_BASE [DIST_CODES] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
    16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
    16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
  };

  typedef struct packed {
    logic [2:0]  req_type;
    logic        final_block;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
  } dfhe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } dfhe_out_t;

  // Huffman codes go out MSB first, so flip them for LSB-first packing
  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) r[i] = v[4-i];
    return r;
  endfunction

  function automatic logic [6:0] rev7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[i] = v[6-i];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[i] = v[8-i];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/deflate_fixed_huffman_symbol_encoder.sv =====
// DEFLATE fixed Huffman (block type 01) symbol encoder. Each item is one
// request: block header, literal, length/distance match, end of block, or
// flush to the byte boundary. The request is held in an input register,
// turned into at most 31 LSB-first bits, and merged into a 38-bit
// accumulator in the same cycle; completed bytes leave through an output
// register one per cycle while out_stall is low, the last byte of each
// item marked. An item that produces at most one byte is taken every
// cycle while the output is not stalled; an item that produces several
// bytes keeps the byte output busy until each has left the single output
// register, and the next item waits in the input register until the
// accumulator holds fewer than 8 bits. Request codes 5 to 7 are dropped
// without output.
`default_nettype none
`include "deflate_fixed_huffman_symbol_encoder_macros.svh"

module deflate_fixed_huffman_symbol_encoder
  import dfhe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dfhe_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dfhe_out_t      out_data
);

  // Input register
  logic     s1_valid_r, s1_valid_nxt;
  dfhe_in_t s1_data_r;

  // Bit accumulator
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  dfhe_out_t out_data_r, out_data_nxt;

  // Encoder signals
  logic [8:0]         len_sat;
  logic [15:0]        dist_sat;
  logic [4:0]         len_idx;
  logic [4:0]         dist_idx;
  logic [2:0]         len_ext;
  logic [3:0]         dist_ext;
  logic [8:0]         len_diff;
  logic [15:0]        dist_diff;
  logic [8:0]         sym_bits;
  logic [3:0]         sym_len;
  logic [WORD_W-1:0]  word;
  logic [NBITS_W-1:0] nbits;
  logic               is_flush;

  // Packer signals
  logic             take;
  logic             out_free;
  logic             emit;
  logic [ACC_W-1:0] m_acc;
  logic [CNT_W-1:0] m_cnt;

  // Hold the item until the accumulator has no complete byte left
  assign take     = s1_valid_r && (cnt_r < CNT_W'(8));
  assign in_stall = s1_valid_r && !take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Saturate match length and distance into their legal ranges
  always_comb begin
    len_sat = s1_data_r.match_length;
    if (len_sat < LEN_MIN) len_sat = LEN_MIN;
    if (len_sat > LEN_MAX) len_sat = LEN_MAX;
    dist_sat = s1_data_r.match_distance;
    if (dist_sat < DIST_MIN) dist_sat = DIST_MIN;
    if (dist_sat > DIST_MAX) dist_sat = DIST_MAX;
  end

  // Find length and distance codes from the base tables
  always_comb begin
    len_idx = '0;
    for (int k = 1; k < LEN_CODES; k++) begin
      if (len_sat >= LEN_BASE[k]) len_idx = 5'(k);
    end
    dist_idx = '0;
    for (int k = 1; k < DIST_CODES; k++) begin
      if (dist_sat >= DIST_BASE[k]) dist_idx = 5'(k);
    end
  end

  // Extra bit counts and offsets from the base values
  always_comb begin
    if (len_idx < LEN_IDX_EXTRA || len_idx == LEN_IDX_LAST) begin
      len_ext = '0;
    end else begin
      len_ext = 3'((len_idx - 5'd4) >> 1'b1 >> 1'b1);
    end
    if (dist_idx < DIST_IDX_EXTRA) begin
      dist_ext = '0;
    end else begin
      dist_ext = 4'((dist_idx - 5'd2) >> 1'b1);
    end
    len_diff  = len_sat - LEN_BASE[len_idx];
    dist_diff = dist_sat - DIST_BASE[dist_idx];
  end

  // Build the bit word for the request
  always_comb begin
    logic [NBITS_W-1:0] pos;
    logic [7:0]         lit;
    lit      = s1_data_r.literal_byte;
    word     = '0;
    nbits    = '0;
    is_flush = 1'b0;
    sym_bits = '0;
    sym_len  = '0;
    pos      = '0;
    case (s1_data_r.req_type)
      REQ_HEADER: begin
        word  = WORD_W'({2'b01, s1_data_r.final_block});
        nbits = NBITS_W'(3);
      end
      REQ_LITERAL: begin
        if (lit < LIT_SPLIT) begin
          word  = WORD_W'(rev8(8'h30 + lit));
          nbits = NBITS_W'(8);
        end else begin
          word  = WORD_W'(rev9(9'h190 + {1'b0, lit} - 9'd144));
          nbits = NBITS_W'(9);
        end
      end
      REQ_MATCH: begin
        if (len_idx < LEN_IDX_SPLIT) begin
          sym_bits = {2'b00, rev7(7'(SYM_LEN_FIRST - SYM_EOB) + {2'b00, len_idx})};
          sym_len  = 4'd7;
        end else begin
          sym_bits = {1'b0, rev8(8'hC0 + {3'b000, len_idx - LEN_IDX_SPLIT})};
          sym_len  = 4'd8;
        end
        word = WORD_W'(sym_bits);
        pos  = NBITS_W'(sym_len);
        word = word | (WORD_W'(len_diff[4:0]) << pos);
        pos  = pos + NBITS_W'(len_ext);
        word = word | (WORD_W'(rev5(dist_idx)) << pos);
        pos  = pos + NBITS_W'(5);
        word = word | (WORD_W'(dist_diff[12:0]) << pos);
        pos  = pos + NBITS_W'(dist_ext);
        nbits = pos;
      end
      REQ_EOB: begin
        word  = WORD_W'(rev7(7'(SYM_EOB - SYM_EOB)));
        nbits = NBITS_W'(7);
      end
      REQ_FLUSH: begin
        is_flush = 1'b1;
      end
      default: begin
        // drop unknown requests
        word  = '0;
        nbits = '0;
      end
    endcase
  end

  // Merge the item into the accumulator
  always_comb begin
    m_acc = acc_r;
    m_cnt = cnt_r;
    if (take) begin
      if (is_flush) begin
        m_cnt = (cnt_r != '0) ? CNT_W'(8) : '0;
      end else begin
        m_acc = acc_r | (ACC_W'(word) << cnt_r);
        m_cnt = cnt_r + CNT_W'(nbits);
      end
    end
  end

  // Emit one byte per cycle when the output register is free
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = out_free && (m_cnt >= CNT_W'(8));

  always_comb begin
    acc_nxt       = m_acc;
    cnt_nxt       = m_cnt;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      acc_nxt                = m_acc >> 4'd8;
      cnt_nxt                = m_cnt - CNT_W'(8);
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_byte  = m_acc[7:0];
      out_data_nxt.last_byte = (m_cnt < CNT_W'(16));
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Bits above the pending count stay clear
  `DFHE_ASSERT_ALWAYS(a_acc_clean, (acc_r >> cnt_r) == '0, "accumulator has stray bits")
  // Pending count never exceeds the accumulator width
  `DFHE_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(ACC_W), "bit count overflow")
  // A byte that is not the last of its item leaves another full byte behind
  `DFHE_ASSERT_IMPL(a_more_bytes, out_valid_r && !out_data_r.last_byte, cnt_r >= CNT_W'(8), "missing byte after non-last byte")
  // A taken flush leaves the accumulator on a byte boundary
  `DFHE_ASSERT_NEXT(a_flush_align, take && is_flush && out_free, cnt_r == '0, "flush left partial byte")

endmodule

`default_nettype wire

// ===== test/deflate_fixed_huffman_symbol_encoder_tb.sv =====
`timescale 1ns / 100ps

module deflate_fixed_huffman_symbol_encoder_tb;
  import dfhe_pkg::*;

  // Request codes the block must drop without output
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    dfhe_in_t         req;
    logic             typed;
    logic [2:0]       count;
    logic [3:0][7:0]  bytes;
  } directed_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  dfhe_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  dfhe_out_t out_data;

  // Expected bytes of the packed stream, oldest first
  dfhe_out_t bytes_due[$];

  // Hand-written bytes for the directed item on the port (count -1: use the packer)
  int              typed_count;
  logic [3:0][7:0] typed_bytes;

  // Private copy of the bit packer state
  logic [37:0] stream_bits;
  logic [5:0]  stream_count;

  int mismatches;
  int quiet_cycles;
  int sends_made;
  int results_taken;
  bit in_calm;
  bit out_calm;

  int length_base [29] = '{
    3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
    35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
  };

  int distance_base [30] = '{
    1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
    257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
    8193, 12289, 16385, 24577
  };

  // Directed items: extremes, every request kind, dropped codes, saturation
  directed_row_t steps [DIRECTED_ROWS] = '{
    '{'{REQ_HEADER,  1'b1, 8'hA5, 9'h1F0, 16'hBEEF}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_FLUSH,   1'b0, 8'h5A, 9'h0AA, 16'h1234}, 1'b1, 3'd1, 32'h03},
    '{'{REQ_FLUSH,   1'b1, 8'hFF, 9'h1FF, 16'hFFFF}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_RSVD5,   1'b1, 8'h3C, 9'h0FF, 16'h8001}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_RSVD6,   1'b0, 8'hC3, 9'h100, 16'h7FFF}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_RSVD7,   1'b1, 8'hFF, 9'h1FF, 16'hFFFF}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_LITERAL, 1'b1, 8'h00, 9'h1FF, 16'hFFFF}, 1'b1, 3'd1, 32'h0C},
    '{'{REQ_LITERAL, 1'b0, 8'hFF, 9'h000, 16'h0000}, 1'b1, 3'd1, 32'hFF},
    '{'{REQ_FLUSH,   1'b0, 8'h00, 9'h000, 16'h0000}, 1'b1, 3'd1, 32'h01},
    '{'{REQ_MATCH,   1'b1, 8'h77, 9'd3,   16'd1},    1'b1, 3'd1, 32'h40},
    '{'{REQ_FLUSH,   1'b1, 8'h11, 9'h022, 16'h0033}, 1'b1, 3'd1, 32'h00},
    '{'{REQ_HEADER,  1'b0, 8'h00, 9'h000, 16'h0000}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_LITERAL, 1'b0, 8'd143, 9'h000, 16'h0000}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_LITERAL, 1'b1, 8'd144, 9'h1FF, 16'hFFFF}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd258, 16'd32768}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd0,   16'd0},     1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b1, 8'hFF, 9'h1FF, 16'hFFFF},  1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd10,  16'd4},     1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd11,  16'd5},     1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd257, 16'd24577}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd227, 16'd24576}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_MATCH,   1'b0, 8'h00, 9'd114, 16'd16385}, 1'b0, 3'd0, 32'h0},
    '{'{REQ_EOB,     1'b1, 8'hFF, 9'h1FF, 16'hFFFF},  1'b0, 3'd0, 32'h0},
    '{'{REQ_FLUSH,   1'b0, 8'h00, 9'h000, 16'h0000},  1'b0, 3'd0, 32'h0},
    '{'{REQ_HEADER,  1'b1, 8'hFF, 9'h1FF, 16'hFFFF},  1'b0, 3'd0, 32'h0}
  };

  deflate_fixed_huffman_symbol_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Reverse the low n bits of v
  function automatic logic [31:0] flip_low(input logic [31:0] v, input int n);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < n; k++) r[k] = v[n-1-k];
    return r;
  endfunction

  // Append n bits above the pending ones, LSB first
  task automatic append_bits(input logic [31:0] v, input int n);
    logic [37:0] chunk;
    if (n == 0) return;
    chunk = 38'(v & ((32'd1 << n) - 32'd1));
    stream_bits = stream_bits | (chunk << stream_count);
    stream_count = stream_count + 6'(n);
  endtask

  // Fixed literal/length code, sent MSB first
  task automatic append_symbol(input int sym);
    int code;
    int len;
    if (sym < 144) begin
      code = 'h30 + sym;
      len = 8;
    end else if (sym < 256) begin
      code = 'h190 + sym - 144;
      len = 9;
    end else if (sym < 280) begin
      code = sym - 256;
      len = 7;
    end else begin
      code = 'hC0 + sym - 280;
      len = 8;
    end
    append_bits(flip_low(code, len), len);
  endtask

  // Length code with extra bits, then distance code with extra bits
  task automatic append_match(input int len, input int distance);
    int idx;
    int ext;
    if (len < 3) len = 3;
    if (len > 258) len = 258;
    if (distance < 1) distance = 1;
    if (distance > 32768) distance = 32768;
    idx = 0;
    while (idx < 28 && length_base[idx+1] <= len) idx++;
    ext = (idx < 8 || idx == 28) ? 0 : (idx - 4) >> 2;
    append_symbol(int'(SYM_LEN_FIRST) + idx);
    append_bits(len - length_base[idx], ext);
    idx = 0;
    while (idx < 29 && distance_base[idx+1] <= distance) idx++;
    ext = (idx < 4) ? 0 : (idx - 2) >> 1;
    append_bits(flip_low(idx, 5), 5);
    append_bits(distance - distance_base[idx], ext);
  endtask

  // Pack one request and pop the completed bytes
  task automatic pack_request(input dfhe_in_t req, output int n, output dfhe_out_t res [4]);
    n = 0;
    for (int k = 0; k < 4; k++) res[k] = '0;
    case (req.req_type)
      REQ_HEADER: append_bits({30'd0, 1'b1, req.final_block}, 3);
      REQ_LITERAL: append_symbol(int'(req.literal_byte));
      REQ_MATCH: append_match(int'(req.match_length), int'(req.match_distance));
      REQ_EOB: append_symbol(int'(SYM_EOB));
      REQ_FLUSH: begin
        if (stream_count > 0 && stream_count < 8) stream_count = 6'd8;
      end
      default: return;
    endcase
    while (stream_count >= 8 && n < 4) begin
      res[n].out_byte = stream_bits[7:0];
      res[n].last_byte = 1'b0;
      stream_bits = stream_bits >> 8;
      stream_count = stream_count - 6'd8;
      n++;
    end
    if (n > 0) res[n-1].last_byte = 1'b1;
  endtask

  // Random request: mostly well-formed symbols, some raw fields and dropped codes
  function automatic dfhe_in_t random_request();
    dfhe_in_t req;
    int pick;
    int span;
    req.final_block = 1'($urandom);
    req.literal_byte = 8'($urandom);
    req.match_length = 9'($urandom);
    req.match_distance = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) req.req_type = REQ_HEADER;
    else if (pick < 45) req.req_type = REQ_LITERAL;
    else if (pick < 78) req.req_type = REQ_MATCH;
    else if (pick < 85) req.req_type = REQ_EOB;
    else if (pick < 94) req.req_type = REQ_FLUSH;
    else req.req_type = 3'($urandom_range(int'(REQ_RSVD5), int'(REQ_RSVD7)));
    if (req.req_type == REQ_MATCH && $urandom_range(0, 9) != 0) begin
      req.match_length = 9'($urandom_range(3, 258));
      span = $urandom_range(0, 15);
      req.match_distance = 16'($urandom_range(1, 1 << span));
    end
    return req;
  endfunction

  // Present one item after a drawn gap and hold it until taken
  task automatic send(input dfhe_in_t req, input int typed_n, input logic [3:0][7:0] typed_b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    typed_count <= typed_n;
    typed_bytes <= typed_b;
    do @(posedge clk); while (in_stall);
    sends_made++;
    if (sends_made % 40 == 0) in_calm = ($urandom_range(0, 2) == 0);
  endtask

  // Drop valid and hold until every expected byte has come out
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
  endtask

  // Check results, predict accepted items, watch for a hang
  always @(posedge clk) begin : monitor
    dfhe_out_t want;
    dfhe_out_t made [4];
    int made_n;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", out_data.out_byte));
        end else begin
          want = bytes_due.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %b, expected %b",
                                      out_data.last_byte, want.last_byte));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pack_request(in_data, made_n, made);
        if (typed_count >= 0) begin
          for (int k = 0; k < typed_count; k++) begin
            want.out_byte = typed_bytes[k];
            want.last_byte = (k == typed_count - 1);
            bytes_due.push_back(want);
          end
        end else begin
          for (int k = 0; k < made_n; k++) bytes_due.push_back(made[k]);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("deflate_fixed_huffman_symbol_encoder_tb: FAIL");
        $finish;
      end
    end
  end

  // Result side: stall a drawn number of cycles before each byte
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    out_calm = 1'b0;
    results_taken = 0;
    @(posedge rst_n);
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_taken++;
      if (results_taken % 48 == 0) out_calm = ($urandom_range(0, 2) == 0);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    dfhe_in_t req;
    int counted;
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    typed_count = -1;
    typed_bytes = '0;
    stream_bits = '0;
    stream_count = '0;
    mismatches = 0;
    quiet_cycles = 0;
    sends_made = 0;
    in_calm = 1'b0;
    clk = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send(steps[r].req, steps[r].typed ? int'(steps[r].count) : -1, steps[r].bytes);

    counted = 0;
    paused = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      req = random_request();
      if (req.req_type <= REQ_FLUSH) counted++;
      send(req, -1, '0);
      if (counted == RANDOM_ITEMS / 2 && !paused) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bytes_due.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came", bytes_due.size()));
    if (mismatches == 0) begin
      $display("deflate_fixed_huffman_symbol_encoder_tb: PASS");
    end else begin
      $display("deflate_fixed_huffman_symbol_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== deflate_fixed_huffman_symbol_encoder.f =====
+incdir+hw/rtl
hw/rtl/dfhe_pkg.sv
hw/rtl/deflate_fixed_huffman_symbol_encoder.sv
test/deflate_fixed_huffman_symbol_encoder_tb.sv
